// ===== sv/ebpt_pkg.sv =====
`timescale 1ns / 1ps

package ebpt_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int LEVEL_W   = 19;
  localparam int GAP_W     = 12;
  localparam int INDEX_W   = 12;
  localparam int TIME_W    = 32;
  localparam int CFG_IDX_W = 2;

  // Peak table size; the index saturates at the smaller of PEAK_SLOTS-1 and the index range.
  localparam int PEAK_SLOTS = 4096;
  localparam logic [INDEX_W-1:0] PEAK_MAX =
    ((PEAK_SLOTS - 1) > ((1 << INDEX_W) - 1)) ? {INDEX_W{1'b1}} : INDEX_W'(PEAK_SLOTS - 1);

  localparam logic [LEVEL_W-1:0] LEVEL_MAX       = {LEVEL_W{1'b1}};
  localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = LEVEL_W'(500);
  localparam logic [GAP_W-1:0]   GAP_RESET       = GAP_W'(16);

  typedef enum logic [1:0] {
    PEAK_NONE   = 2'd0,
    PEAK_OPENED = 2'd1,
    PEAK_MOVED  = 2'd2
  } peak_event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL_THRESHOLD = 2'd0,
    REG_PEAK_GAP        = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] window_sum;
    peak_event_t        peak_event;
    logic [INDEX_W-1:0] peak_index;
    logic [TIME_W-1:0]  peak_time;
    logic [LEVEL_W-1:0] peak_level;
    logic               table_full;
  } result_t;

endpackage

// ===== sv/ebpt_if.sv =====
`timescale 1ns / 1ps

interface ebpt_in_if;
  import ebpt_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface ebpt_out_if;
  import ebpt_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] window_sum;
  logic [1:0]         peak_event;
  logic [INDEX_W-1:0] peak_index;
  logic [TIME_W-1:0]  peak_time;
  logic [LEVEL_W-1:0] peak_level;
  logic               table_full;
  modport source (output valid, output window_sum, output peak_event, output peak_index,
                  output peak_time, output peak_level, output table_full, input ready);
  modport sink (input valid, input window_sum, input peak_event, input peak_index,
                input peak_time, input peak_level, input table_full, output ready);
endinterface

// ===== sv/echo_burst_peak_tracker_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir   Payload
// samples   in    sample (s16)
// results   out   window_sum, peak_event, peak_index, peak_time, peak_level, table_full
// cfg       in    cfg_we / cfg_index / cfg_data, write only
//
// One sample per cycle sustained while the result queue is not full; each result passes
// through the sample register and then the result queue before it is offered.
// The sample register feeds combinational window/peak logic, the sum update and the
// 32-bit time distance compare; results land in a two-entry output queue.
// Synchronous reset clears the window, counters, peak record and queue and reloads the
// register defaults. A stalled output still lets one more sample in; ready drops only when
// the queue is full and the sample register is occupied.

module echo_burst_peak_tracker_unit #(
  parameter int WINDOW_LEN = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ebpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ebpt_pkg::LEVEL_W-1:0]    cfg_data,
  ebpt_in_if.sink                         samples,
  ebpt_out_if.source                      results
);
  import ebpt_pkg::*;

  localparam int SUM_RAW_W = $clog2(WINDOW_LEN * (1 << (SAMPLE_W - 1)) + 1);
  localparam int SUM_W     = (SUM_RAW_W > LEVEL_W) ? SUM_RAW_W : LEVEL_W;

  logic [LEVEL_W-1:0] level_threshold;
  logic [GAP_W-1:0]   peak_gap;

  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;

  logic [SAMPLE_W-1:0] taps [WINDOW_LEN];
  logic [SUM_W-1:0]    running_sum;
  logic [TIME_W-1:0]   sample_counter;
  logic [TIME_W-1:0]   last_peak_time;
  logic [LEVEL_W-1:0]  last_peak_level;
  logic [INDEX_W-1:0]  current_peak;

  result_t    rq [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  logic                s1_fire;
  logic                in_fire;
  logic                pop;
  logic [SAMPLE_W-1:0] mag;
  logic [SUM_W-1:0]    running_sum_next;
  logic [LEVEL_W-1:0]  level;
  logic [TIME_W-1:0]   peak_dist;
  logic [TIME_W-1:0]   last_peak_time_next;
  logic [LEVEL_W-1:0]  last_peak_level_next;
  logic [INDEX_W-1:0]  current_peak_next;
  peak_event_t         ev;
  result_t             res;
  result_t             head;

  assign s1_fire       = s1_valid && (count != 2'd2);
  assign samples.ready = !s1_valid || s1_fire;
  assign in_fire       = samples.valid && samples.ready;
  assign pop           = (count != 2'd0) && results.ready;

  // Magnitude of the most negative sample is 0x8000, which still fits unsigned.
  assign mag = s1_sample[SAMPLE_W-1] ? (~s1_sample + SAMPLE_W'(1)) : s1_sample;

  assign running_sum_next = running_sum - SUM_W'(taps[WINDOW_LEN-1]) + SUM_W'(mag);
  assign level = (running_sum_next > SUM_W'(LEVEL_MAX)) ? LEVEL_MAX
                                                        : running_sum_next[LEVEL_W-1:0];
  assign peak_dist = sample_counter - last_peak_time;

  always_comb begin
    ev                   = PEAK_NONE;
    last_peak_time_next  = last_peak_time;
    last_peak_level_next = last_peak_level;
    current_peak_next    = current_peak;
    if (level > level_threshold) begin
      if (peak_dist > TIME_W'(peak_gap)) begin
        if (current_peak < PEAK_MAX) begin
          current_peak_next = current_peak + INDEX_W'(1);
        end
        last_peak_time_next  = sample_counter;
        last_peak_level_next = level;
        ev                   = PEAK_OPENED;
      end else if (level > last_peak_level) begin
        last_peak_time_next  = sample_counter;
        last_peak_level_next = level;
        ev                   = PEAK_MOVED;
      end
    end
  end

  always_comb begin
    res.window_sum = level;
    res.peak_event = ev;
    res.peak_index = current_peak_next;
    res.peak_time  = last_peak_time_next;
    res.peak_level = last_peak_level_next;
    res.table_full = (current_peak_next >= PEAK_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_threshold <= THRESHOLD_RESET;
      peak_gap        <= GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEVEL_THRESHOLD: level_threshold <= cfg_data;
        REG_PEAK_GAP:        peak_gap        <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample <= samples.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        taps[i] <= '0;
      end
      running_sum     <= '0;
      sample_counter  <= '0;
      last_peak_time  <= '0;
      last_peak_level <= '0;
      current_peak    <= '0;
    end else if (s1_fire) begin
      taps[0] <= mag;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        taps[i] <= taps[i-1];
      end
      running_sum     <= running_sum_next;
      sample_counter  <= sample_counter + TIME_W'(1);
      last_peak_time  <= last_peak_time_next;
      last_peak_level <= last_peak_level_next;
      current_peak    <= current_peak_next;
    end
  end

  // Two-entry result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (s1_fire) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(s1_fire) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      rq[wr_ptr] <= res;
    end
  end

  assign head               = rq[rd_ptr];
  assign results.valid      = (count != 2'd0);
  assign results.window_sum = head.window_sum;
  assign results.peak_event = head.peak_event;
  assign results.peak_index = head.peak_index;
  assign results.peak_time  = head.peak_time;
  assign results.peak_level = head.peak_level;
  assign results.table_full = head.table_full;

endmodule
